// ----- rtl/mfcd_pkg.sv -----
// Shared types, byte codes and helper functions of the command deframer.
`timescale 1ns / 1ps
`default_nettype none

package mfcd_pkg;

  // Marker bytes of the framing scheme.
  localparam logic [7:0] BYTE_HDR_A = 8'hFA;
  localparam logic [7:0] BYTE_RESET = 8'hFB;
  localparam logic [7:0] BYTE_HDR_C = 8'hFC;
  localparam logic [7:0] BYTE_HDR_D = 8'hFD;
  localparam logic [7:0] BYTE_CLOSE = 8'hFE;

  // Frame kind codes reported on the result.
  localparam logic [1:0] KIND_A = 2'd0;
  localparam logic [1:0] KIND_C = 2'd1;
  localparam logic [1:0] KIND_D = 2'd2;

  // Reset value of the frame length limit register.
  localparam logic [7:0] LIMIT_RESET = 8'd120;

  // Header plus closing bytes that are not counted as payload, less one.
  localparam logic [7:0] FRAME_OVERHEAD_M1 = 8'd3;

  // One result item.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_commit;
    logic       frame_abort;
    logic [1:0] frame_kind;
    logic [7:0] frame_length;
  } result_t;

  // Registered input byte handed from the input stage to the core.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_stage_t;

  // True for any of the three header bytes.
  function automatic logic is_header(input logic [7:0] b);
    return (b == BYTE_HDR_A) || (b == BYTE_HDR_C) || (b == BYTE_HDR_D);
  endfunction

  // Kind code of a header byte; only meaningful when is_header is true.
  function automatic logic [1:0] kind_of(input logic [7:0] b);
    logic [1:0] k;
    case (b)
      BYTE_HDR_A: k = KIND_A;
      BYTE_HDR_C: k = KIND_C;
      BYTE_HDR_D: k = KIND_D;
      default:    k = KIND_A;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mfcd_intf.sv -----
// Handshake channel interfaces: byte input, result output and limit configuration.
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel.
interface mfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface mfcd_out_if;
  logic             valid;
  logic             ready;
  mfcd_pkg::result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// Frame length limit write channel.
interface mfcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_length_limit;

  modport source (output valid, output frame_length_limit, input ready);
  modport sink   (input valid, input frame_length_limit, output ready);
endinterface

`default_nettype wire

// ----- rtl/mfcd_in_stage.sv -----
// Input register stage that holds one received byte for the core.
`timescale 1ns / 1ps
`default_nettype none

module mfcd_in_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mfcd_in_if.sink                    in_i,
  input  wire logic                  adv_i,
  output mfcd_pkg::byte_stage_t      stage_o
);
  import mfcd_pkg::*;

  logic       vld_q;
  logic [7:0] data_q;
  logic       load;

  // The register takes a new item when empty or when the core consumes the held one.
  assign in_i.ready = !vld_q || adv_i;
  assign load       = in_i.valid && in_i.ready;

  // Valid flag of the held byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  // Byte payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_i.in_byte;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.data = data_q;

endmodule

`default_nettype wire

// ----- rtl/mfcd_core.sv -----
// Deframing state machine, limit register and result register.
`timescale 1ns / 1ps
`default_nettype none

module mfcd_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mfcd_pkg::byte_stage_t stage_i,
  output logic                       adv_o,
  mfcd_cfg_if.sink                   cfg_i,
  mfcd_out_if.source                 out_o
);
  import mfcd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HEAD  = 2'd1,
    PH_OPEN  = 2'd2,
    PH_CLOSE = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] count_q, count_d;
  logic [7:0] limit_q;
  logic       out_valid_q;
  result_t    result_q, result_d;
  logic       take;
  logic       hdr;
  logic [1:0] hk;
  logic [7:0] count_inc;

  // The result register frees up when empty or when its item is taken.
  assign adv_o = !out_valid_q || out_o.ready;
  assign take  = stage_i.vld && adv_o;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.frame_length_limit;
    end
  end

  // Next state and result for the held byte.
  always_comb begin
    hdr       = is_header(stage_i.data);
    hk        = kind_of(stage_i.data);
    count_inc = 8'(count_q + 8'd1);
    phase_d   = phase_q;
    kind_d    = kind_q;
    count_d   = count_q;
    result_d  = '0;
    case (phase_q)
      PH_IDLE: begin
        if (hdr) begin
          kind_d  = hk;
          count_d = 8'd1;
          phase_d = PH_HEAD;
        end else begin
          count_d = 8'd0;
        end
      end
      PH_HEAD: begin
        if (hdr && (hk == kind_q)) begin
          count_d = count_inc;
          phase_d = PH_OPEN;
        end else begin
          count_d = 8'd0;
          phase_d = PH_IDLE;
        end
      end
      PH_OPEN: begin
        result_d.frame_kind = kind_q;
        count_d             = count_inc;
        if (stage_i.data == BYTE_CLOSE) begin
          phase_d = PH_CLOSE;
        end else if (hdr) begin
          // A new header aborts the frame and starts the next one.
          result_d.frame_abort = 1'b1;
          kind_d               = hk;
          count_d              = 8'd1;
          phase_d              = PH_HEAD;
        end else if (stage_i.data == BYTE_RESET) begin
          result_d.frame_abort = 1'b1;
          count_d              = 8'd0;
          phase_d              = PH_IDLE;
        end else begin
          result_d.payload_valid = 1'b1;
          result_d.payload_byte  = stage_i.data;
        end
        // Reaching the length limit aborts and drops any passed byte.
        if (count_d >= limit_q) begin
          result_d.frame_abort   = 1'b1;
          result_d.payload_valid = 1'b0;
          result_d.payload_byte  = 8'd0;
          count_d                = 8'd0;
          phase_d                = PH_IDLE;
        end
      end
      PH_CLOSE: begin
        result_d.frame_kind = kind_q;
        if (stage_i.data == BYTE_CLOSE) begin
          result_d.frame_commit = 1'b1;
          result_d.frame_length = 8'(count_q - FRAME_OVERHEAD_M1);
        end else begin
          result_d.frame_abort = 1'b1;
        end
        count_d = 8'd0;
        phase_d = PH_IDLE;
      end
      default: begin
        count_d = 8'd0;
        phase_d = PH_IDLE;
      end
    endcase
    // The kind is reported only alongside payload, commit or abort.
    if (!result_d.payload_valid && !result_d.frame_commit && !result_d.frame_abort) begin
      result_d.frame_kind = KIND_A;
    end
  end

  // Frame state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      kind_q      <= KIND_A;
      count_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        count_q <= count_d;
      end
      if (adv_o) begin
        out_valid_q <= stage_i.vld;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.result = result_q;

endmodule

`default_nettype wire

// ----- rtl/marker_framed_command_deframer_unit.sv -----
// Top level of the marker-framed command deframer.
//
//   Channel  Direction  Contents
//   in_i     sink       in_byte: one received byte per item
//   cfg_i    sink       frame_length_limit register write
//   out_o    source     one result item per input item
//
// Each byte passes an input register and a result register, and one item per cycle is
// sustained when the result side takes every cycle.
// The result register stalls on out_o.ready; the input register keeps taking
// items while it or the result register has room.
// Reset clears the frame state to idle and the limit to 120. Limit writes are
// always ready and apply from the next byte that reaches the state machine.
`timescale 1ns / 1ps
`default_nettype none

module marker_framed_command_deframer_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mfcd_in_if.sink    in_i,
  mfcd_cfg_if.sink   cfg_i,
  mfcd_out_if.source out_o
);
  import mfcd_pkg::*;

  byte_stage_t stage;
  logic        adv;

  // Input byte register.
  mfcd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .stage_o (stage)
  );

  // State machine and result register.
  mfcd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .adv_o   (adv),
    .cfg_i   (cfg_i),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/marker_framed_command_deframer_unit_tb.sv -----
// Self-checking testbench for the marker-framed command deframer unit.
`timescale 1ns / 1ps

module marker_framed_command_deframer_unit_tb;
  import mfcd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_COUNT = 7;
  localparam int PHASE_ITEMS = 190;
  localparam result_t NO_RESULT = '0;

  // Deframer state as tracked by the predictor.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_OPEN,
    ST_CLOSE
  } deframe_state_e;

  // One row of directed stimulus; typed rows carry their own expectation.
  typedef struct {
    logic [7:0] in_byte;
    bit         typed;
    result_t    res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  mfcd_in_if  in_if ();
  mfcd_cfg_if cfg_if ();
  mfcd_out_if out_if ();

  marker_framed_command_deframer_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // Predictor state and the limit register copy.
  deframe_state_e st;
  logic [1:0]     hdr_kind;
  logic [7:0]     frame_bytes;
  logic [7:0]     limit_reg;

  result_t  results_due[$];
  dir_row_t directed_rows[$];

  int sender_idle_pct;
  int receiver_idle_pct;
  int items_sent;
  int errors;
  int commits_seen;
  int aborts_seen;
  int payload_seen;
  int cycle_count;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result of one accepted byte and advances the frame state.
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t    r;
    logic       hdr;
    logic [1:0] k;
    r   = NO_RESULT;
    hdr = (b == BYTE_HDR_A) || (b == BYTE_HDR_C) || (b == BYTE_HDR_D);
    k   = (b == BYTE_HDR_C) ? KIND_C : (b == BYTE_HDR_D) ? KIND_D : KIND_A;
    case (st)
      ST_IDLE: begin
        if (hdr) begin
          hdr_kind    = k;
          frame_bytes = 8'd1;
          st          = ST_HEAD;
        end else begin
          frame_bytes = 8'd0;
        end
      end
      ST_HEAD: begin
        if (hdr && k == hdr_kind) begin
          frame_bytes = frame_bytes + 8'd1;
          st          = ST_OPEN;
        end else begin
          frame_bytes = 8'd0;
          st          = ST_IDLE;
        end
      end
      ST_OPEN: begin
        // The kind reported is that of the frame being left, even on restart.
        r.frame_kind = hdr_kind;
        frame_bytes  = frame_bytes + 8'd1;
        if (b == BYTE_CLOSE) begin
          st = ST_CLOSE;
        end else if (hdr) begin
          r.frame_abort = 1'b1;
          hdr_kind      = k;
          frame_bytes   = 8'd1;
          st            = ST_HEAD;
        end else if (b == BYTE_RESET) begin
          r.frame_abort = 1'b1;
          frame_bytes   = 8'd0;
          st            = ST_IDLE;
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
        end
        // Reaching the limit drops the frame, or a restarted header search.
        if (frame_bytes >= limit_reg) begin
          r.frame_abort   = 1'b1;
          r.payload_valid = 1'b0;
          r.payload_byte  = 8'd0;
          frame_bytes     = 8'd0;
          st              = ST_IDLE;
        end
      end
      default: begin
        r.frame_kind = hdr_kind;
        if (b == BYTE_CLOSE) begin
          r.frame_commit = 1'b1;
          r.frame_length = frame_bytes - FRAME_OVERHEAD_M1;
        end else begin
          r.frame_abort = 1'b1;
        end
        frame_bytes = 8'd0;
        st          = ST_IDLE;
      end
    endcase
    if (!r.payload_valid && !r.frame_commit && !r.frame_abort) begin
      r.frame_kind = KIND_A;
    end
    return r;
  endfunction

  function automatic result_t payload_res(input logic [1:0] kind, input logic [7:0] b);
    result_t r;
    r               = NO_RESULT;
    r.payload_valid = 1'b1;
    r.payload_byte  = b;
    r.frame_kind    = kind;
    return r;
  endfunction

  function automatic result_t commit_res(input logic [1:0] kind, input logic [7:0] len);
    result_t r;
    r              = NO_RESULT;
    r.frame_commit = 1'b1;
    r.frame_kind   = kind;
    r.frame_length = len;
    return r;
  endfunction

  function automatic result_t abort_res(input logic [1:0] kind);
    result_t r;
    r             = NO_RESULT;
    r.frame_abort = 1'b1;
    r.frame_kind  = kind;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed, input result_t res);
    dir_row_t row;
    row.in_byte = b;
    row.typed   = typed;
    row.res     = res;
    directed_rows.push_back(row);
  endfunction

  // Offers one byte, with a random gap first, and books its expected result.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t res);
    result_t r;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    r = deframe_byte(b);
    results_due.push_back(typed ? res : r);
    items_sent++;
  endtask

  // Holds the sender until every booked result has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] value);
    cfg_if.valid              <= 1'b1;
    cfg_if.frame_length_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    limit_reg = value;
  endtask

  // Sends one frame, mostly well formed, sometimes broken or led by noise.
  task automatic send_random_frame(input logic [7:0] lim);
    logic [7:0] fbytes[$];
    logic [7:0] hb;
    logic [7:0] pb;
    int         n;
    int         near_limit;
    int         mode;
    int         pos;
    int         noise;
    case ($urandom_range(0, 2))
      0:       hb = BYTE_HDR_A;
      1:       hb = BYTE_HDR_C;
      default: hb = BYTE_HDR_D;
    endcase
    near_limit = (lim > 8'd4) ? int'(lim) - 4 : 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: n = $urandom_range(0, 8);
      6, 7:             n = $urandom_range(0, 40);
      8:                n = near_limit + $urandom_range(0, 1);
      default:          n = $urandom_range(0, 255);
    endcase
    fbytes.push_back(hb);
    fbytes.push_back(hb);
    repeat (n) begin
      do pb = 8'($urandom_range(0, 255));
      while (pb >= BYTE_HDR_A && pb <= BYTE_CLOSE);
      fbytes.push_back(pb);
    end
    fbytes.push_back(BYTE_CLOSE);
    fbytes.push_back(BYTE_CLOSE);
    // Corrupt a minority of frames.
    mode = $urandom_range(0, 99);
    pos  = $urandom_range(0, fbytes.size() - 1);
    if (mode >= 70 && mode < 85) begin
      fbytes[pos] = 8'($urandom_range(BYTE_HDR_A, BYTE_CLOSE));
    end else if (mode >= 85 && mode < 92) begin
      fbytes[pos] = 8'($urandom_range(0, 255));
    end else if (mode >= 92) begin
      noise = $urandom_range(1, 4);
      repeat (noise) fbytes.push_front(8'($urandom_range(0, 255)));
    end
    foreach (fbytes[i]) send_byte(fbytes[i], 1'b0, NO_RESULT);
  endtask

  // Receiver: random stalls and the field-by-field comparison.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    out_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.result;
      if (results_due.size() == 0) begin
        $error("result item with nothing expected: %0h", got);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got.payload_valid !== want.payload_valid) begin
          $error("payload_valid: expected %0h, got %0h", want.payload_valid,
                 got.payload_valid);
          errors++;
        end
        if (got.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
          errors++;
        end
        if (got.frame_commit !== want.frame_commit) begin
          $error("frame_commit: expected %0h, got %0h", want.frame_commit, got.frame_commit);
          errors++;
        end
        if (got.frame_abort !== want.frame_abort) begin
          $error("frame_abort: expected %0h, got %0h", want.frame_abort, got.frame_abort);
          errors++;
        end
        if (got.frame_kind !== want.frame_kind) begin
          $error("frame_kind: expected %0h, got %0h", want.frame_kind, got.frame_kind);
          errors++;
        end
        if (got.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0h, got %0h", want.frame_length, got.frame_length);
          errors++;
        end
        commits_seen += want.frame_commit;
        aborts_seen  += want.frame_abort;
        payload_seen += want.payload_valid;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus: reset, directed rows, then random phases at several limits.
  initial begin
    logic [7:0] phase_limits[PHASE_COUNT];
    int         phase_start;
    bit         paused;
    in_if.valid               = 1'b0;
    in_if.in_byte             = 8'd0;
    cfg_if.valid              = 1'b0;
    cfg_if.frame_length_limit = 8'd0;
    out_if.ready              = 1'b0;
    rst_ni                    = 1'b0;
    sender_idle_pct           = 10;
    receiver_idle_pct         = 69;
    items_sent                = 0;
    errors                    = 0;
    commits_seen              = 0;
    aborts_seen               = 0;
    payload_seen              = 0;
    cycle_count               = 0;
    paused                    = 1'b0;
    st                        = ST_IDLE;
    hdr_kind                  = KIND_A;
    frame_bytes               = 8'd0;
    limit_reg                 = LIMIT_RESET;

    phase_limits = '{8'd5, 8'd255, 8'd0, 8'd30, 8'd12, 8'd200, 8'd1};
    phase_limits[4] = 8'($urandom_range(5, 255));

    // Idle bytes, a mismatched header pair, a short frame and its commit.
    add_row(8'h00, 1'b1, NO_RESULT);
    add_row(8'hFF, 1'b1, NO_RESULT);
    add_row(BYTE_HDR_A, 1'b1, NO_RESULT);
    add_row(BYTE_HDR_C, 1'b1, NO_RESULT);
    add_row(BYTE_HDR_C, 1'b0, NO_RESULT);
    add_row(BYTE_HDR_C, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b1, payload_res(KIND_C, 8'h00));
    add_row(8'hFF, 1'b1, payload_res(KIND_C, 8'hFF));
    add_row(BYTE_CLOSE, 1'b0, NO_RESULT);
    add_row(BYTE_CLOSE, 1'b1, commit_res(KIND_C, 8'd2));
    // A header inside the payload aborts and restarts the search.
    add_row(BYTE_HDR_D, 1'b0, NO_RESULT);
    add_row(BYTE_HDR_D, 1'b0, NO_RESULT);
    add_row(8'h55, 1'b0, NO_RESULT);
    add_row(BYTE_HDR_A, 1'b1, abort_res(KIND_D));
    add_row(BYTE_HDR_A, 1'b0, NO_RESULT);
    add_row(8'hAA, 1'b0, NO_RESULT);
    // The reset byte inside the payload aborts to idle.
    add_row(BYTE_RESET, 1'b1, abort_res(KIND_A));
    // A lone closing byte followed by anything else aborts.
    add_row(BYTE_HDR_A, 1'b0, NO_RESULT);
    add_row(BYTE_HDR_A, 1'b0, NO_RESULT);
    add_row(BYTE_CLOSE, 1'b0, NO_RESULT);
    add_row(8'h33, 1'b1, abort_res(KIND_A));
    // An empty frame commits with length zero.
    add_row(BYTE_HDR_D, 1'b0, NO_RESULT);
    add_row(BYTE_HDR_D, 1'b0, NO_RESULT);
    add_row(BYTE_CLOSE, 1'b0, NO_RESULT);
    add_row(BYTE_CLOSE, 1'b1, commit_res(KIND_D, 8'd0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].in_byte, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases, each at its own limit, idle pattern changing along the way.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 2) begin
        sender_idle_pct   = 10;
        receiver_idle_pct = 69;
      end else if (p < 4) begin
        sender_idle_pct   = 69;
        receiver_idle_pct = 10;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      drain();
      write_limit(phase_limits[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_random_frame(limit_reg);
        if (p == 3 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    // Let the last results come out, then a few quiet cycles.
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes: 25 directed, then random frames at %0d limit settings.",
             items_sent, PHASE_COUNT);
    $display("Observed %0d payload bytes, %0d commits and %0d aborts.", payload_seen,
             commits_seen, aborts_seen);
    if (errors == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mfcd_pkg.sv
rtl/mfcd_intf.sv
rtl/mfcd_in_stage.sv
rtl/mfcd_core.sv
rtl/marker_framed_command_deframer_unit.sv
tb/sv/marker_framed_command_deframer_unit_tb.sv
